@@ hdl/pos_pkg.sv @@
// Shared constants, types and helpers for the priority order sorter.
package pos_pkg;

  localparam int SLOTS  = 16;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int TOT_W  = $clog2(SLOTS + 2);
  localparam int FLD_W  = 5;

  localparam logic [7:0] DEFAULT_REPEAT = 8'd5;
  localparam logic [7:0] MODE_LOW       = 8'h20;
  localparam logic [7:0] MODE_MID       = 8'h21;
  localparam logic [7:0] MODE_HIGH      = 8'h22;

  typedef enum logic [0:0] {
    REG_MODE   = 1'b0,
    REG_REPEAT = 1'b1
  } reg_idx_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // insert the accepted entry, or flag a drop when full
    logic load_final; // accepted entry closes the set
    logic scan;       // test one held entry against the repeat slot
    logic emit;       // issue result beats into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic last_issued;
  } stat_t;

  function automatic logic [FLD_W-1:0] fit_field(input logic [TOT_W-1:0] v);
    logic [TOT_W+FLD_W-1:0] w;
    w = {{FLD_W{1'b0}}, v};
    return w[FLD_W-1:0];
  endfunction

endpackage

@@ hdl/priority_order_sorter_core.sv @@
// After the final beat is accepted, the held list is scanned for the repeat slot
// (up to the first match), then result beats go through the output register.
// Throughput: one entry per cycle while loading (insertion array), one result beat
// per cycle while emitting and m_tready allows it (single read port on the id array).
// Reset (rst, synchronous): set empty, no flag, output register empty,
// mode 0 and repeat slot 5.
module priority_order_sorter_core (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // entry beats
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // slot_id[7:0], priority_key[15:8]
  input  logic        s_tlast,   // final_entry
  // result beats
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // slot_out[7:0], position[12:8], total_count[17:13]
  output logic [0:0]  m_tuser,   // overflowed[0]
  output logic        m_tlast    // end_of_list
);

  pos_pkg::cmd_t  cmd;
  pos_pkg::stat_t stat;

  // Controller: accepts entries in the load phase, then steps the scan and
  // drives emission until the last beat has been issued.
  pos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: sorted insertion cells, repeat scan and output register. The
  // output register decouples the sides, so loading of the next set may start
  // while the last beat of the previous list still waits.
  pos_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

@@ hdl/pos_ctrl.sv @@
// Sequencer for the load, scan and emit phases.
module pos_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  input  logic           s_tlast,
  output logic           s_tready,
  input  pos_pkg::stat_t stat,
  output pos_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state, state_next;
  logic   in_fire;

  assign s_tready = (state == ST_LOAD);
  assign in_fire  = s_tvalid && s_tready;

  always_comb begin
    cmd            = '0;
    cmd.load       = in_fire;
    cmd.load_final = in_fire && s_tlast;
    cmd.scan       = (state == ST_SCAN);
    cmd.emit       = (state == ST_EMIT);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: if (in_fire && s_tlast) state_next = ST_SCAN;
      ST_SCAN: if (stat.scan_done) state_next = ST_EMIT;
      ST_EMIT: if (stat.last_issued) state_next = ST_LOAD;
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hdl/pos_dp.sv @@
// Insertion array, repeat scan, emission counters and output register.
module pos_dp (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [7:0]     cfg_data,
  input  logic [15:0]    s_tdata,
  input  pos_pkg::cmd_t  cmd,
  output pos_pkg::stat_t stat,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [23:0]    m_tdata,
  output logic [0:0]     m_tuser,
  output logic           m_tlast
);

  localparam int IDX_W = pos_pkg::IDX_W;
  localparam int CNT_W = pos_pkg::CNT_W;
  localparam int TOT_W = pos_pkg::TOT_W;

  logic [7:0]       mode_code;
  logic [7:0]       repeat_slot;
  logic [7:0]       keys [pos_pkg::SLOTS];
  logic [7:0]       ids  [pos_pkg::SLOTS];
  logic [CNT_W-1:0] count;
  logic             drop;
  logic [pos_pkg::SLOTS-1:0] ge;

  logic [7:0]       in_id, in_key;
  logic             room, ins;

  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] dup_idx;
  logic             found;
  logic             dup_en, match, scan_last;

  logic [IDX_W-1:0] rd;
  logic [TOT_W-1:0] pos;
  logic [TOT_W-1:0] total;
  logic             dup_used;
  logic             out_load, is_last, repeat_now;

  assign in_id  = s_tdata[7:0];
  assign in_key = s_tdata[15:8];
  assign room   = (count < CNT_W'(pos_pkg::SLOTS));
  assign ins    = cmd.load && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_code   <= '0;
      repeat_slot <= pos_pkg::DEFAULT_REPEAT;
    end else if (cfg_we) begin
      unique case (pos_pkg::reg_idx_t'(cfg_index))
        pos_pkg::REG_MODE:   mode_code   <= cfg_data;
        pos_pkg::REG_REPEAT: repeat_slot <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each cell keeps, takes the new entry, or takes its upper neighbor.
  for (genvar p = 0; p < pos_pkg::SLOTS; p++) begin : g_cell
    assign ge[p] = (CNT_W'(p) < count) && (keys[p] >= in_key);
    if (p == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (ins && !ge[p]) begin
          keys[p] <= in_key;
          ids[p]  <= in_id;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (ins && !ge[p]) begin
          if (ge[p-1]) begin
            keys[p] <= in_key;
            ids[p]  <= in_id;
          end else begin
            keys[p] <= keys[p-1];
            ids[p]  <= ids[p-1];
          end
        end
      end
    end
  end

  assign dup_en = (mode_code == pos_pkg::MODE_LOW) || (mode_code == pos_pkg::MODE_MID) ||
                  (mode_code == pos_pkg::MODE_HIGH);
  assign match     = dup_en && (ids[scan_idx] == repeat_slot);
  assign scan_last = ((CNT_W'(scan_idx) + CNT_W'(1)) == count);
  assign stat.scan_done = cmd.scan && (!dup_en || match || scan_last);

  assign total      = TOT_W'(count) + TOT_W'(found);
  assign out_load   = cmd.emit && (!m_tvalid || m_tready);
  assign is_last    = (pos == total - TOT_W'(1));
  assign repeat_now = found && (rd == dup_idx) && !dup_used;
  assign stat.last_issued = out_load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      drop     <= 1'b0;
      scan_idx <= '0;
      found    <= 1'b0;
      dup_idx  <= '0;
      rd       <= '0;
      pos      <= '0;
      dup_used <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (room) count <= count + CNT_W'(1);
        else      drop  <= 1'b1;
      end
      if (cmd.load_final) scan_idx <= '0;
      if (cmd.scan) begin
        scan_idx <= scan_idx + IDX_W'(1);
        found    <= match;
        dup_idx  <= scan_idx;
      end
      if (stat.scan_done) begin
        rd       <= '0;
        pos      <= '0;
        dup_used <= 1'b0;
      end
      if (out_load) begin
        pos <= pos + TOT_W'(1);
        if (repeat_now) dup_used <= 1'b1;
        else            rd       <= rd + IDX_W'(1);
        if (is_last) begin
          count <= '0;
          drop  <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'd0, pos_pkg::fit_field(total), pos_pkg::fit_field(pos), ids[rd]};
      m_tuser <= drop;
      m_tlast <= is_last;
    end
  end

endmodule

@@ hdl/pos_checker.sv @@
// Port-level checks for the priority order sorter, bound to the top level.
module pos_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tlast
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat present after reset");

  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == ((m_tdata[12:8] + 5'd1) == m_tdata[17:13])))
    else $error("end of list does not match position and count");

  a_no_load_midlist: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("entry taken while list is being emitted");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[17:13] != 5'd0))
    else $error("empty list emitted");

endmodule

bind priority_order_sorter_core pos_checker u_pos_checker (.*);

@@ dv/priority_order_sorter_core_test.sv @@
// Self-checking stream testbench for the priority order sorter core.
module priority_order_sorter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no beat on either side before the run is declared hung. The
  // longest legal quiet stretch is the long receiver hold-off below.
  localparam int IDLE_LIMIT    = 4000;
  // Quiet time before a register write: scan of a full list plus output slack.
  localparam int SETTLE_CYCLES = pos_pkg::SLOTS + 24;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 28;

  typedef struct {
    logic [7:0] slot_id;
    logic [7:0] key;
    logic       final_entry;
    logic       drain_first; // keep this beat back until the list is fully out
  } entry_t;

  typedef struct packed {
    logic [7:0] slot_out;
    logic [4:0] position;
    logic [4:0] total_count;
    logic       overflowed;
    logic       end_of_list;
  } result_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [0:0]  cfg_index = pos_pkg::REG_MODE;
  logic [7:0]  cfg_data  = 8'd0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata   = 16'd0;   // slot_id[7:0], priority_key[15:8]
  logic        s_tlast   = 1'b0;    // final_entry
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;             // slot_out[7:0], position[12:8], total_count[17:13]
  logic [0:0]  m_tuser;             // overflowed[0]
  logic        m_tlast;             // end_of_list

  entry_t  entry_backlog[$];  // beats waiting to be offered
  result_t order_due[$];      // ordered-list beats predicted but not yet seen

  // Shadow of the sorter: held list, ordered by key, highest first.
  logic [7:0] shadow_ids [0:pos_pkg::SLOTS];
  logic [7:0] shadow_keys[0:pos_pkg::SLOTS-1];
  int         held         = 0;
  logic       dropped      = 1'b0;
  logic [7:0] shadow_mode  = 8'd0;
  logic [7:0] shadow_slot  = pos_pkg::DEFAULT_REPEAT;

  int   errors        = 0;
  int   send_idle_pct = 22;
  int   recv_idle_pct = 78;
  int   hold_reqs     = 0;
  int   hold_seen     = 0;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;
  logic in_taken      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  priority_order_sorter_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // Insert one entry into the shadow list; on the final entry, apply the
  // repeat-slot duplication and queue the whole ordered list as due beats.
  task automatic place_entry(input logic [7:0] id, input logic [7:0] key,
                             input logic last);
    int      p;
    int      n;
    int      k;
    int      j;
    result_t r;
    if (held < pos_pkg::SLOTS) begin
      // Walk past every held key that is strictly smaller; equal keys stay ahead.
      p = held;
      while (p > 0 && shadow_keys[p-1] < key) begin
        shadow_keys[p] = shadow_keys[p-1];
        shadow_ids[p]  = shadow_ids[p-1];
        p--;
      end
      shadow_keys[p] = key;
      shadow_ids[p]  = id;
      held++;
    end else begin
      // Capacity full: drop the entry, remember it for the whole set.
      dropped = 1'b1;
    end
    if (last) begin
      n = held;
      if (shadow_mode == pos_pkg::MODE_LOW || shadow_mode == pos_pkg::MODE_MID ||
          shadow_mode == pos_pkg::MODE_HIGH) begin
        // Only the first place holding the repeat slot gets a second place.
        k = 0;
        while (k < held && shadow_ids[k] != shadow_slot) k++;
        if (k < held) begin
          for (j = held; j > k; j--) shadow_ids[j] = shadow_ids[j-1];
          n = held + 1;
        end
      end
      for (k = 0; k < n; k++) begin
        r.slot_out    = shadow_ids[k];
        r.position    = 5'(k);
        r.total_count = 5'(n);
        r.overflowed  = dropped;
        r.end_of_list = (k == n - 1);
        order_due.push_back(r);
      end
      held    = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic push_entry(input logic [7:0] id, input logic [7:0] key,
                            input logic last, input logic drain);
    entry_t e;
    e.slot_id     = id;
    e.key         = key;
    e.final_entry = last;
    e.drain_first = drain;
    entry_backlog.push_back(e);
  endtask

  // Write one register at a falling edge and mirror it in the shadow copy.
  task automatic write_reg(input pos_pkg::reg_idx_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == pos_pkg::REG_MODE) shadow_mode = val;
    else shadow_slot = val;
  endtask

  // Wait until every queued beat is accepted and every due result is out,
  // then give the core time to go idle.
  task automatic settle();
    while (entry_backlog.size() != 0 || s_tvalid || order_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sampling side: record accepted entries, check result beats, run the
  // watchdog. Everything here reads values settled since the falling edge.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    in_taken = !rst && s_tvalid && s_tready;
    if (in_taken) place_entry(s_tdata[7:0], s_tdata[15:8], s_tlast);
    if (!rst && m_tvalid && m_tready) begin
      got.slot_out    = m_tdata[7:0];
      got.position    = m_tdata[12:8];
      got.total_count = m_tdata[17:13];
      got.overflowed  = m_tuser[0];
      got.end_of_list = m_tlast;
      if (order_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing due: slot_out=%0d position=%0d ",
                 $time, got.slot_out, got.position,
                 "total_count=%0d overflowed=%0b end_of_list=%0b",
                 got.total_count, got.overflowed, got.end_of_list);
      end else begin
        want = order_due.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: result mismatch: expected slot_out=%0d position=%0d ",
                   $time, want.slot_out, want.position,
                   "total_count=%0d overflowed=%0b end_of_list=%0b",
                   want.total_count, want.overflowed, want.end_of_list);
          $display("%0t:                  actual slot_out=%0d position=%0d ",
                   $time, got.slot_out, got.position,
                   "total_count=%0d overflowed=%0b end_of_list=%0b",
                   got.total_count, got.overflowed, got.end_of_list);
        end
      end
    end
    // Watchdog: reset the count on any beat, otherwise advance it.
    if (rst || in_taken || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("priority_order_sorter_core_test failed");
        $finish;
      end
    end
  end

  // Entry driver: hold the current beat until it is taken, then either idle
  // or present the next one from the backlog.
  always @(negedge clk) begin
    entry_t nxt;
    logic   holding;
    holding = s_tvalid && !in_taken;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!holding) begin
      if (entry_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct &&
          !(entry_backlog[0].drain_first && order_due.size() != 0)) begin
        nxt = entry_backlog.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {nxt.key, nxt.slot_id};
        s_tlast  <= nxt.final_entry;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    int         i;
    int         n;
    int         r;
    int         budget;
    int         phase;
    logic [7:0] id;
    logic [7:0] key;
    logic [7:0] mode;
    logic [7:0] rep;
    bit         tie;
    bit         drain;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings (mode 0): repeat slot 5 is present but not duplicated.
    push_entry(8'd5, 8'h80, 1'b0, 1'b0);
    push_entry(8'd0, 8'd0, 1'b1, 1'b0);
    settle();

    write_reg(pos_pkg::REG_MODE, pos_pkg::MODE_MID);
    write_reg(pos_pkg::REG_REPEAT, pos_pkg::DEFAULT_REPEAT);
    @(posedge clk);
    // Single-entry set at the bottom of both fields.
    push_entry(8'd0, 8'd0, 1'b1, 1'b0);
    // Ties keep arrival order; only the first slot 5 gets a second place.
    // Hold the first beat back until the previous list has drained.
    push_entry(8'd255, 8'd255, 1'b0, 1'b1);
    push_entry(8'd5, 8'd128, 1'b0, 1'b0);
    push_entry(8'd9, 8'd128, 1'b0, 1'b0);
    push_entry(8'd5, 8'd128, 1'b0, 1'b0);
    push_entry(8'd3, 8'd255, 1'b1, 1'b0);
    // Overfill with the final entry dropped: a full list plus the duplicate.
    for (i = 0; i <= pos_pkg::SLOTS; i++)
      push_entry(8'(i), 8'(i % 3), i == pos_pkg::SLOTS, 1'b0);
    settle();

    // Random sets: first sender-light/receiver-heavy idling, then the
    // reverse, then none at all.
    for (phase = 0; phase < 6; phase++) begin
      send_idle_pct = (phase < 2) ? 22 : (phase < 4) ? 78 : 0;
      recv_idle_pct = (phase < 2) ? 78 : (phase < 4) ? 22 : 0;
      case (phase)
        0: begin mode = pos_pkg::MODE_LOW;  rep = 8'd0;   end
        1: begin mode = 8'hFF;              rep = 8'hFF;  end
        2: begin mode = pos_pkg::MODE_HIGH; rep = 8'hFF;  end
        3: begin mode = 8'h1F;              rep = 8'($urandom_range(0, 255)); end
        4: begin mode = pos_pkg::MODE_MID;  rep = 8'($urandom_range(0, 15));  end
        default: begin mode = 8'h00; rep = 8'($urandom_range(0, 255)); end
      endcase
      write_reg(pos_pkg::REG_MODE, mode);
      write_reg(pos_pkg::REG_REPEAT, rep);
      @(posedge clk);
      // Stall the output long enough for the core to fill and push back.
      if (phase == 4) hold_reqs++;
      budget = 0;
      while (budget < PHASE_ITEMS) begin
        // Mostly short sets, some long, a few past capacity.
        r = $urandom_range(0, 9);
        n = (r < 7) ? $urandom_range(1, 6) :
            (r < 9) ? $urandom_range(7, pos_pkg::SLOTS) :
                      $urandom_range(pos_pkg::SLOTS + 1, pos_pkg::SLOTS + 4);
        tie   = $urandom_range(0, 1);
        drain = ($urandom_range(0, 6) == 0);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0:       id = shadow_slot;
            1:       id = 8'($urandom_range(0, 7));
            default: id = 8'($urandom_range(0, 255));
          endcase
          key = tie ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
          push_entry(id, key, i == n - 1, drain && i == 0);
        end
        budget += n;
      end
      settle();
    end

    if (errors == 0 && order_due.size() == 0) begin
      $display("priority_order_sorter_core_test passed");
    end else begin
      $display("priority_order_sorter_core_test failed");
    end
    $finish;
  end

endmodule

@@ priority_order_sorter_core.f @@
hdl/pos_pkg.sv
hdl/pos_ctrl.sv
hdl/pos_dp.sv
hdl/priority_order_sorter_core.sv
hdl/pos_checker.sv
dv/priority_order_sorter_core_test.sv
